### rtl/fsfr_pkg.sv
// ----------------------------------------------------------------------------
// fsfr_pkg: shared definitions for the four-digit segment frame renderer
// Holds the frame sizes, the seven-segment patterns, the glass map and the
// function that turns one decimal digit into display-memory bits.
// ----------------------------------------------------------------------------
package fsfr_pkg;

  // Display-memory addresses written per frame, and how many are sent.
  localparam int unsigned NUM_ADDRESSES = 32;
  localparam int unsigned MAX_WRITES    = 32;
  localparam int unsigned WRITE_COUNT   =
      (NUM_ADDRESSES > MAX_WRITES) ? MAX_WRITES : NUM_ADDRESSES;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned NUMBER_W = 16;

  // Only addresses 0 to 10 can carry segments; the rest are always zero.
  localparam int unsigned IMG_ADDRS = 11;
  localparam int unsigned IMG_W     = IMG_ADDRS * NIBBLE_W;

  // Saturated values fit in 14 bits; quotients by ten fit in 10 bits.
  localparam int unsigned REST_W    = 14;
  localparam int unsigned QUOT_W    = 10;
  localparam int unsigned PROD_W    = 27;
  localparam int unsigned RECIP_SH  = 16;
  localparam logic [NUMBER_W-1:0] TOP_VALUE = 16'd9999;
  // floor(v * 6554 / 2^16) equals floor(v / 10) for every v up to 9999.
  localparam logic [12:0] RECIP10 = 13'd6554;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned NUM_SEGS   = 7;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Icon positions as {address, common line}.
  localparam logic [5:0] COLON_BIT = {4'd8, 2'd3};
  localparam logic [5:0] PM_BIT    = {4'd3, 2'd3};

  typedef logic [IMG_W-1:0] img_t;

  // Segment bit masks per digit that exist on the glass.
  localparam logic [NUM_SEGS-1:0] GLASS_PRESENT [NUM_DIGITS] = '{
    7'b1111111, 7'b1111111, 7'b1111111, 7'b1000110
  };

  // Glass map as {address, common line}, [digit 0 = rightmost][segment a..g].
  localparam logic [5:0] GLASS_SPOT [NUM_DIGITS][NUM_SEGS] = '{
    '{ {4'd10, 2'd3}, {4'd10, 2'd2}, {4'd10, 2'd1}, {4'd9, 2'd1},
       {4'd8, 2'd1},  {4'd9, 2'd3},  {4'd9, 2'd2} },
    '{ {4'd8, 2'd2},  {4'd7, 2'd3},  {4'd7, 2'd1},  {4'd6, 2'd1},
       {4'd6, 2'd2},  {4'd6, 2'd3},  {4'd7, 2'd2} },
    '{ {4'd4, 2'd3},  {4'd5, 2'd2},  {4'd5, 2'd1},  {4'd4, 2'd1},
       {4'd3, 2'd1},  {4'd3, 2'd2},  {4'd4, 2'd2} },
    '{ {4'd0, 2'd0},  {4'd2, 2'd2},  {4'd2, 2'd1},  {4'd0, 2'd0},
       {4'd0, 2'd0},  {4'd0, 2'd0},  {4'd1, 2'd2} }
  };

  // Seven-segment pattern, bit 0 = a up to bit 6 = g.
  function automatic logic [NUM_SEGS-1:0] seg_pattern(input logic [3:0] digit);
    logic [NUM_SEGS-1:0] patt;
    unique case (digit)
      4'd0:    patt = 7'h3F;
      4'd1:    patt = 7'h06;
      4'd2:    patt = 7'h5B;
      4'd3:    patt = 7'h4F;
      4'd4:    patt = 7'h66;
      4'd5:    patt = 7'h6D;
      4'd6:    patt = 7'h7D;
      4'd7:    patt = 7'h07;
      4'd8:    patt = 7'h7F;
      4'd9:    patt = 7'h6F;
      default: patt = '0;
    endcase
    return patt;
  endfunction

  // Display-memory bits lit by one digit at one position.
  function automatic img_t digit_image(input logic [1:0] pos, input logic [3:0] digit);
    img_t                img;
    logic [NUM_SEGS-1:0] patt;
    patt = seg_pattern(digit) & GLASS_PRESENT[pos];
    img  = '0;
    for (int s = 0; s < NUM_SEGS; s++) begin
      if (patt[s]) begin
        img[GLASS_SPOT[pos][s]] = 1'b1;
      end
    end
    return img;
  endfunction

endpackage

### rtl/fsfr_front.sv
// ----------------------------------------------------------------------------
// fsfr_front: number intake and frame image builder
// Saturates the number, peels off one decimal digit per cycle through a
// reciprocal multiply, blanks leading zeros and collects the lit bits.
// ----------------------------------------------------------------------------
module fsfr_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fsfr_pkg::NUMBER_W-1:0]     number_value_i,
  input  logic                              colon_lit_i,
  input  logic                              pm_lit_i,
  output logic                              img_valid_o,
  input  logic                              img_ready_i,
  output fsfr_pkg::img_t                    img_o
);
  import fsfr_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [1:0]        step_q, step_d;
  logic [REST_W-1:0] rest_q, rest_d;
  img_t              img_q, img_d;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [REST_W-1:0] remainder;
  logic              shown;
  logic              accept;
  logic              push;
  logic [REST_W-1:0] sat_value;
  img_t              icons;

  assign prod      = PROD_W'(rest_q) * PROD_W'(RECIP10);
  assign quot      = prod[RECIP_SH +: QUOT_W];
  assign remainder = rest_q - REST_W'({quot, 3'b000}) - REST_W'({quot, 1'b0});
  // A digit other than the rightmost is blank when it and every digit to its left are zero.
  assign shown     = (step_q == 2'd0) || (rest_q != '0);

  assign sat_value = (number_value_i > TOP_VALUE) ? REST_W'(TOP_VALUE)
                                                  : number_value_i[REST_W-1:0];

  always_comb begin
    icons             = '0;
    icons[COLON_BIT]  = colon_lit_i;
    icons[PM_BIT]     = pm_lit_i;
  end

  assign push        = done_q && img_ready_i;
  assign in_ready_o  = !busy_q || push;
  assign accept      = in_valid_i && in_ready_o;
  assign img_valid_o = done_q;
  assign img_o       = img_q;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    rest_d = rest_q;
    img_d  = img_q;
    if (accept) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = '0;
      rest_d = sat_value;
      img_d  = icons;
    end else if (push) begin
      busy_d = 1'b0;
      done_d = 1'b0;
    end else if (busy_q && !done_q) begin
      step_d = step_q + 2'd1;
      rest_d = REST_W'(quot);
      if (shown) begin
        img_d = img_q | digit_image(step_q, remainder[3:0]);
      end
      if (step_q == 2'(NUM_DIGITS - 1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    img_q  <= img_d;
  end

endmodule

### rtl/fsfr_queue.sv
// ----------------------------------------------------------------------------
// fsfr_queue: short frame image queue
// Holds finished frame images between the builder and the write sequencer.
// ----------------------------------------------------------------------------
module fsfr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  fsfr_pkg::img_t wr_img_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output fsfr_pkg::img_t rd_img_o
);
  import fsfr_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  img_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_img_o   = slot_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_img_i;
    end
  end

endmodule

### rtl/fsfr_back.sv
// ----------------------------------------------------------------------------
// fsfr_back: display-memory write sequencer
// Walks the addresses of one frame image in ascending order and presents
// one registered write word per address, marking the final one.
// ----------------------------------------------------------------------------
module fsfr_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             img_valid_i,
  output logic                             img_ready_o,
  input  fsfr_pkg::img_t                   img_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fsfr_pkg::ADDR_W-1:0]      ram_address_o,
  output logic [fsfr_pkg::NIBBLE_W-1:0]    ram_nibble_o,
  output logic                             last_write_o
);
  import fsfr_pkg::*;

  logic                busy_q;
  logic [ADDR_W-1:0]   cnt_q;
  img_t                img_q;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [NIBBLE_W-1:0] out_nib_q;
  logic                out_last_q;

  logic                advance;
  logic                take;
  img_t                src_img;
  logic [ADDR_W-1:0]   src_addr;
  logic [NIBBLE_W-1:0] src_nib;

  function automatic logic [NIBBLE_W-1:0] pick(input img_t img, input logic [ADDR_W-1:0] a);
    logic [NIBBLE_W-1:0] nib;
    nib = '0;
    for (int i = 0; i < IMG_ADDRS; i++) begin
      if (a == ADDR_W'(i)) begin
        nib = img[i*NIBBLE_W +: NIBBLE_W];
      end
    end
    return nib;
  endfunction

  assign advance     = !out_valid_q || out_ready_i;
  assign take        = advance && !busy_q && img_valid_i;
  assign img_ready_o = advance && !busy_q;
  assign src_img     = busy_q ? img_q : img_i;
  assign src_addr    = busy_q ? cnt_q : '0;
  assign src_nib     = pick(src_img, src_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      if (busy_q) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(WRITE_COUNT - 1)) begin
          busy_q <= 1'b0;
        end
      end else if (img_valid_i) begin
        out_valid_q <= 1'b1;
        cnt_q       <= ADDR_W'(1);
        busy_q      <= (WRITE_COUNT > 1);
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      img_q <= img_i;
    end
    if (advance) begin
      out_addr_q <= src_addr;
      out_nib_q  <= src_nib;
      out_last_q <= (src_addr == ADDR_W'(WRITE_COUNT - 1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ram_address_o = out_addr_q;
  assign ram_nibble_o  = out_nib_q;
  assign last_write_o  = out_last_q;

endmodule

### rtl/four_digit_segment_frame_render.sv
// ----------------------------------------------------------------------------
// four_digit_segment_frame_render: four-digit segment display frame renderer
// Turns a number and two icon flags into one frame of display-memory writes.
// ----------------------------------------------------------------------------
// Each input word carries a number (saturated to 9999), a colon flag and a PM
// flag, and yields a frame of WRITE_COUNT output words (32 by default), one
// per display-memory address in ascending order, with tlast on the final
// address. Leading zero digits are blanked and the rightmost digit is always
// shown. The output side delivers one word per cycle while m_axis_tready is
// high, so the address counter of the write sequencer sets the sustained
// rate of one input word per frame. The front end builds a frame image after
// a word is accepted, one decimal digit per cycle through a reciprocal
// multiply, and a two-frame queue lets it take further input words while a
// frame is still being written out. Once the builder finishes and the output
// side is free, the first write passes the queue slot and the output register.
module four_digit_segment_frame_render (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] number_value, [16] colon_lit, [17] pm_lit, [23:18] zero
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] ram_address, [8:5] ram_nibble, [15:9] zero
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import fsfr_pkg::*;

  logic                fr_valid, fr_ready;
  img_t                fr_img;
  logic                bk_valid, bk_ready;
  img_t                bk_img;
  logic [ADDR_W-1:0]   ram_address;
  logic [NIBBLE_W-1:0] ram_nibble;

  fsfr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .number_value_i (s_axis_tdata[15:0]),
    .colon_lit_i    (s_axis_tdata[16]),
    .pm_lit_i       (s_axis_tdata[17]),
    .img_valid_o    (fr_valid),
    .img_ready_i    (fr_ready),
    .img_o          (fr_img)
  );

  fsfr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_img_i   (fr_img),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_img_o   (bk_img)
  );

  fsfr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .img_valid_i   (bk_valid),
    .img_ready_o   (bk_ready),
    .img_i         (bk_img),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .ram_address_o (ram_address),
    .ram_nibble_o  (ram_nibble),
    .last_write_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, ram_nibble, ram_address};

  // The final word of a frame always carries the highest written address.
  a_last_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (ram_address == ADDR_W'(WRITE_COUNT - 1)))
    else $error("tlast on the wrong address");

  // Within a frame the next word follows at once with the next address.
  a_addr_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && (ram_address == $past(ram_address) + 1'b1)))
    else $error("frame addresses not consecutive");

  // Addresses beyond the glass map never carry segment bits.
  a_blank_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (ram_address >= ADDR_W'(IMG_ADDRS))) |-> (ram_nibble == '0))
    else $error("segment bits on an unused address");

endmodule
